// ===== rtl/tfd_pkg.sv =====
// shared types, constants and crc helper for the telemetry frame deframer
`timescale 1ns / 1ps

package tfd_pkg;

   localparam int MAX_FRAME = 64;

   localparam int CNT_W  = 7;
   localparam int BYTE_W = 8;
   localparam int TIME_W = 16;
   localparam int QOFS_W = 6;
   localparam int CSR_W  = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic FUNC_CHUNK = 1'b0;
   localparam logic FUNC_BYTE  = 1'b1;

   localparam logic [BYTE_W-1:0] LEN_MIN = BYTE_W'(2);
   localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_FRAME - 2);
   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0]  QUALITY_BASE = CNT_W'(3);
   localparam logic [CNT_W-1:0]  SIZE_MIN = CNT_W'(4);
   localparam logic [CNT_W-1:0]  LINK_STATS_MIN_SIZE = CNT_W'(14);
   localparam logic [CNT_W-1:0]  CNT_TYPE = CNT_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_RADIO    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SYNC     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_STATS_TYPE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUALITY_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLYNOMIAL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTIAL_TIMEOUT = 3'd5;

   localparam logic [BYTE_W-1:0] RST_HEADER_RADIO    = 8'd234;
   localparam logic [BYTE_W-1:0] RST_HEADER_SYNC     = 8'd200;
   localparam logic [BYTE_W-1:0] RST_LINK_STATS_TYPE = 8'd20;
   localparam logic [QOFS_W-1:0] RST_QUALITY_OFFSET  = 6'd2;
   localparam logic [BYTE_W-1:0] RST_CRC_POLYNOMIAL  = 8'd213;
   localparam logic [BYTE_W-1:0] RST_PARTIAL_TIMEOUT = 8'd10;

   typedef struct packed {
      logic [BYTE_W-1:0] header_radio;
      logic [BYTE_W-1:0] header_sync;
      logic [BYTE_W-1:0] link_stats_type;
      logic [QOFS_W-1:0] quality_offset;
      logic [BYTE_W-1:0] crc_polynomial;
      logic [BYTE_W-1:0] partial_timeout;
   } cfg_type;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] data_byte;
      logic [TIME_W-1:0] now;
      logic              force_restart;
   } req_beat_type;

   typedef struct packed {
      logic              crc_ok;
      logic [CNT_W-1:0]  frame_size;
      logic [BYTE_W-1:0] frame_type;
      logic [BYTE_W-1:0] header_value;
      logic              link_stats;
      logic              receiver_seen;
   } rsp_beat_type;

   // msb-first crc-8 over one byte, unrolled
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic [BYTE_W-1:0] poly);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/tfd_if.sv =====
// valid/ready channel interfaces for request and response beats
`timescale 1ns / 1ps

interface tfd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [tfd_pkg::BYTE_W-1:0]  data_byte;
   logic [tfd_pkg::TIME_W-1:0]  now;
   logic                        force_restart;

   modport source (output valid, output func, output data_byte, output now,
                   output force_restart, input ready);
   modport sink   (input valid, input func, input data_byte, input now,
                   input force_restart, output ready);
endinterface

interface tfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        crc_ok;
   logic [tfd_pkg::CNT_W-1:0]   frame_size;
   logic [tfd_pkg::BYTE_W-1:0]  frame_type;
   logic [tfd_pkg::BYTE_W-1:0]  header_value;
   logic                        link_stats;
   logic                        receiver_seen;

   modport source (output valid, output crc_ok, output frame_size, output frame_type,
                   output header_value, output link_stats, output receiver_seen,
                   input ready);
   modport sink   (input valid, input crc_ok, input frame_size, input frame_type,
                   input header_value, input link_stats, input receiver_seen,
                   output ready);
endinterface

// ===== rtl/tfd_parser.sv =====
// frame parser state and single-pass next-state logic
`timescale 1ns / 1ps

module tfd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tfd_pkg::req_beat_type item,
   input  tfd_pkg::cfg_type      cfg,
   output logic                  result_valid,
   output tfd_pkg::rsp_beat_type result
);
   import tfd_pkg::*;

   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] opening_header_ff, opening_header_in;
   logic [BYTE_W-1:0] length_value_ff, length_value_in;
   logic [BYTE_W-1:0] type_value_ff, type_value_in;
   logic              quality_nonzero_ff, quality_nonzero_in;
   logic [BYTE_W-1:0] running_crc_ff, running_crc_in;
   logic [TIME_W-1:0] start_time_ff, start_time_in;

   logic              is_header;
   logic [TIME_W-1:0] age;
   logic [CNT_W-1:0]  count_next;
   logic [CNT_W:0]    size_expected;
   logic [CNT_W-1:0]  quality_index;
   logic              link_stats;

   assign is_header     = (item.data_byte == cfg.header_radio) ||
                          (item.data_byte == cfg.header_sync);
   assign age           = item.now - start_time_ff;
   assign count_next    = byte_count_ff + CNT_W'(1);
   assign size_expected = (CNT_W+1)'({1'b0, length_value_ff}) + (CNT_W+1)'(2);
   assign quality_index = QUALITY_BASE + CNT_W'(cfg.quality_offset);

   always_comb begin
      byte_count_in      = byte_count_ff;
      opening_header_in  = opening_header_ff;
      length_value_in    = length_value_ff;
      type_value_in      = type_value_ff;
      quality_nonzero_in = quality_nonzero_ff;
      running_crc_in     = running_crc_ff;
      start_time_in      = start_time_ff;
      result_valid       = 1'b0;
      link_stats         = 1'b0;
      result             = '0;

      if (item.func == FUNC_CHUNK) begin
         // chunk start check
         if (item.force_restart || (byte_count_ff >= CNT_MAX) ||
             ((byte_count_ff != '0) && (age > TIME_W'(cfg.partial_timeout)))) begin
            byte_count_in = '0;
         end
      end else if (byte_count_ff == '0) begin
         if (is_header) begin
            start_time_in     = item.now;
            opening_header_in = item.data_byte;
            byte_count_in     = CNT_W'(1);
         end
      end else if (byte_count_ff == CNT_W'(1)) begin
         if ((item.data_byte < LEN_MIN) || (item.data_byte > LEN_MAX)) begin
            // bad length, a header byte reopens a frame
            if (is_header) begin
               opening_header_in = item.data_byte;
               byte_count_in     = CNT_W'(1);
            end else begin
               byte_count_in = '0;
            end
         end else begin
            length_value_in    = item.data_byte;
            running_crc_in     = '0;
            quality_nonzero_in = 1'b0;
            byte_count_in      = CNT_W'(2);
         end
      end else begin
         if (byte_count_ff == CNT_TYPE) begin
            type_value_in = item.data_byte;
         end
         if (byte_count_ff == quality_index) begin
            quality_nonzero_in = (item.data_byte != '0);
         end
         if ({1'b0, byte_count_ff} <= length_value_ff) begin
            running_crc_in = crc8_step(running_crc_ff, item.data_byte, cfg.crc_polynomial);
         end
         byte_count_in = count_next;
         if ((count_next >= SIZE_MIN) && ({1'b0, count_next} == size_expected)) begin
            link_stats           = (type_value_in == cfg.link_stats_type) &&
                                   (count_next >= LINK_STATS_MIN_SIZE);
            result_valid         = 1'b1;
            result.crc_ok        = (running_crc_ff == item.data_byte);
            result.frame_size    = count_next;
            result.frame_type    = type_value_in;
            result.header_value  = opening_header_ff;
            result.link_stats    = link_stats;
            result.receiver_seen = link_stats && quality_nonzero_in;
            byte_count_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff      <= '0;
         opening_header_ff  <= '0;
         length_value_ff    <= '0;
         type_value_ff      <= '0;
         quality_nonzero_ff <= 1'b0;
         running_crc_ff     <= '0;
         start_time_ff      <= '0;
      end else if (step) begin
         byte_count_ff      <= byte_count_in;
         opening_header_ff  <= opening_header_in;
         length_value_ff    <= length_value_in;
         type_value_ff      <= type_value_in;
         quality_nonzero_ff <= quality_nonzero_in;
         running_crc_ff     <= running_crc_in;
         start_time_ff      <= start_time_in;
      end
   end

endmodule

// ===== rtl/telemetry_frame_deframer_top.sv =====
// telemetry frame deframer top level: csr bank, input and result registers
//
// usage
//   req_bus carries one beat per received serial byte (func 1) or per chunk
//   start check (func 0, with now and force_restart). rsp_bus carries one
//   beat per completed frame: crc_ok, frame_size, frame_type, header_value,
//   link_stats and receiver_seen. csr_* writes the six control registers;
//   the user must write them only while no request beat is in flight; the
//   block does not enforce it. an accepted beat is held in the input
//   register; as it advances it is parsed and any response is registered.
//   throughput: one request beat per cycle while the response is not
//   stalled; the crc update and the frame checks are a single pass of logic
//   between the input register and the response register.
//   reset: control registers return to their defaults, the parser goes to
//   hunting for a header and both channels are empty.
//   stall: a held response keeps its payload; one further request beat is
//   taken into the input register and then req_bus.ready drops until the
//   response is taken.
`timescale 1ns / 1ps

module telemetry_frame_deframer_top (
   input  logic                          clock,
   input  logic                          reset,
   tfd_req_if.sink                       req_bus,
   tfd_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_en,
   input  logic [tfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tfd_pkg::CSR_W-1:0]     csr_wdata
);
   import tfd_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         req_valid_ff, req_valid_in;
   req_beat_type req_beat_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff;
   logic         advance;
   logic         req_take;
   logic         result_valid;
   rsp_beat_type result;

   // csr bank
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HEADER_RADIO:    cfg_in.header_radio    = csr_wdata;
            CSR_HEADER_SYNC:     cfg_in.header_sync     = csr_wdata;
            CSR_LINK_STATS_TYPE: cfg_in.link_stats_type = csr_wdata;
            CSR_QUALITY_OFFSET:  cfg_in.quality_offset  = csr_wdata[QOFS_W-1:0];
            CSR_CRC_POLYNOMIAL:  cfg_in.crc_polynomial  = csr_wdata;
            CSR_PARTIAL_TIMEOUT: cfg_in.partial_timeout = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // handshake
   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result_valid;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_radio    <= RST_HEADER_RADIO;
         cfg_ff.header_sync     <= RST_HEADER_SYNC;
         cfg_ff.link_stats_type <= RST_LINK_STATS_TYPE;
         cfg_ff.quality_offset  <= RST_QUALITY_OFFSET;
         cfg_ff.crc_polynomial  <= RST_CRC_POLYNOMIAL;
         cfg_ff.partial_timeout <= RST_PARTIAL_TIMEOUT;
         req_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_beat_ff.func          <= req_bus.func;
         req_beat_ff.data_byte     <= req_bus.data_byte;
         req_beat_ff.now           <= req_bus.now;
         req_beat_ff.force_restart <= req_bus.force_restart;
      end
      if (advance && result_valid) begin
         rsp_beat_ff <= result;
      end
   end

   tfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (req_beat_ff),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.crc_ok        = rsp_beat_ff.crc_ok;
   assign rsp_bus.frame_size    = rsp_beat_ff.frame_size;
   assign rsp_bus.frame_type    = rsp_beat_ff.frame_type;
   assign rsp_bus.header_value  = rsp_beat_ff.header_value;
   assign rsp_bus.link_stats    = rsp_beat_ff.link_stats;
   assign rsp_bus.receiver_seen = rsp_beat_ff.receiver_seen;

endmodule

// ===== rtl/tfd_checker.sv =====
// port-level checker for the telemetry frame deframer, with its bind
`timescale 1ns / 1ps

module tfd_checker (
   input  logic      clock,
   input  logic      reset,
   tfd_rsp_if.source rsp_bus
);
   import tfd_pkg::*;

   // held response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid)
      else $error("response dropped while stalled");

   // frame size within the legal window
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.frame_size >= SIZE_MIN) && (rsp_bus.frame_size <= CNT_MAX))
      else $error("frame size out of range");

   // receiver seen only on link statistics frames
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.receiver_seen |-> rsp_bus.link_stats)
      else $error("receiver seen without link statistics");

   // link statistics needs a long enough frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.link_stats |-> rsp_bus.frame_size >= LINK_STATS_MIN_SIZE)
      else $error("link statistics on short frame");

   // no response right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("response valid after reset");

endmodule

bind telemetry_frame_deframer_top tfd_checker u_tfd_checker (
   .clock   (clock),
   .reset   (reset),
   .rsp_bus (rsp_bus)
);
